// File: sv/assert_macros.svh
// Assertion macros used by the perfect gas EOS top level.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define EOS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define EOS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/eos_pkg.sv
// Types, constants and the square root step for the perfect gas EOS pipeline.
// No dependencies.
package eos_pkg;

	localparam int unsigned GAMMA_W     = 32;
	localparam int unsigned IN_W        = 48;
	localparam int unsigned PRES_W      = 64;
	localparam int unsigned SLOPE_W     = 52;
	localparam int unsigned ROOT_W      = 44;
	localparam int unsigned RAD_W       = 2 * ROOT_W;
	localparam int unsigned REM_W       = ROOT_W + 3;
	localparam int unsigned SQRT_BITS   = 4;
	localparam int unsigned SQRT_STAGES = ROOT_W / SQRT_BITS;

	localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 32'h1000_0000;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 32'd375809638;

	typedef struct packed {
		logic [PRES_W-1:0]  pressure;
		logic [SLOPE_W-1:0] slope;
		logic               zero_density;
		logic               pressure_saturated;
	} eos_side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_acc_t;

	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] trial;
		sqrt_acc_t        o;
		r     = {a.rem[REM_W-3:0], pair};
		trial = {1'b0, a.root, 2'b01};
		if (r >= trial) begin
			o.rem  = r - trial;
			o.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// File: sv/eos_front.sv
// Multiply front end: slope, pressure and the sound speed radicand in four stages.
// Depends on eos_pkg.
module eos_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [eos_pkg::GAMMA_W-1:0]       gamma,
	input  logic [eos_pkg::IN_W-1:0]          density,
	input  logic [eos_pkg::IN_W-1:0]          spec_energy,
	output logic                              out_valid,
	output logic [eos_pkg::RAD_W-1:0]         radicand,
	output eos_pkg::eos_side_t                side
);

	logic [eos_pkg::GAMMA_W-1:0] gm1;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [55:0] pp_lo_s1, pp_hi_s1;
	logic [63:0] gg_s1;
	logic [47:0] e_s1, e_s2;
	logic        zero_s1, zero_s2, zero_s3, zero_s4;

	logic [51:0] slope_s2, slope_s3, slope_s4;
	logic [55:0] sp00_s2, sp01_s2, sp10_s2, sp11_s2;
	logic [79:0] slope_full;

	logic [111:0] snd_full;
	logic [87:0]  y_s3, y_s4;
	logic [49:0]  pq00_s3, pq01_s3, pq10_s3, pq11_s3;

	logic [99:0] pres_full;
	logic [63:0] pres_s4;
	logic        sat_s4;

	assign gm1 = (gamma > eos_pkg::GAMMA_ONE) ? gamma - eos_pkg::GAMMA_ONE : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: gamma-1 times density halves, gamma*(gamma-1)
	always_ff @(posedge clk) begin
		pp_lo_s1 <= 56'(gm1) * 56'(density[23:0]);
		pp_hi_s1 <= 56'(gm1) * 56'(density[47:24]);
		gg_s1    <= 64'(gamma) * 64'(gm1);
		e_s1     <= spec_energy;
		zero_s1  <= (density == '0);
	end

	// s2: slope; radicand partial products
	assign slope_full = (80'(pp_hi_s1) << 24) + 80'(pp_lo_s1);

	always_ff @(posedge clk) begin
		slope_s2 <= slope_full[79:28];
		sp00_s2  <= 56'(gg_s1[31:0])  * 56'(e_s1[23:0]);
		sp01_s2  <= 56'(gg_s1[31:0])  * 56'(e_s1[47:24]);
		sp10_s2  <= 56'(gg_s1[63:32]) * 56'(e_s1[23:0]);
		sp11_s2  <= 56'(gg_s1[63:32]) * 56'(e_s1[47:24]);
		e_s2     <= e_s1;
		zero_s2  <= zero_s1;
	end

	// s3: radicand sum; pressure partial products
	assign snd_full = 112'(sp00_s2) + (112'(sp01_s2) << 24)
		+ (112'(sp10_s2) << 32) + (112'(sp11_s2) << 56);

	always_ff @(posedge clk) begin
		y_s3     <= snd_full[111:24];
		pq00_s3  <= 50'(slope_s2[25:0])  * 50'(e_s2[23:0]);
		pq01_s3  <= 50'(slope_s2[25:0])  * 50'(e_s2[47:24]);
		pq10_s3  <= 50'(slope_s2[51:26]) * 50'(e_s2[23:0]);
		pq11_s3  <= 50'(slope_s2[51:26]) * 50'(e_s2[47:24]);
		slope_s3 <= slope_s2;
		zero_s3  <= zero_s2;
	end

	// s4: pressure sum and clip
	assign pres_full = 100'(pq00_s3) + (100'(pq01_s3) << 24)
		+ (100'(pq10_s3) << 26) + (100'(pq11_s3) << 50);

	always_ff @(posedge clk) begin
		sat_s4   <= |pres_full[99:96];
		pres_s4  <= (|pres_full[99:96]) ? '1 : pres_full[95:32];
		y_s4     <= y_s3;
		slope_s4 <= slope_s3;
		zero_s4  <= zero_s3;
	end

	assign out_valid               = v_s4;
	assign radicand                = y_s4;
	assign side.pressure           = pres_s4;
	assign side.slope              = slope_s4;
	assign side.zero_density       = zero_s4;
	assign side.pressure_saturated = sat_s4;

endmodule

// File: sv/eos_sqrt_stage.sv
// One stage of the pipelined square root: four result bits per stage.
// Depends on eos_pkg.
module eos_sqrt_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  eos_pkg::sqrt_acc_t          in_acc,
	input  logic [eos_pkg::RAD_W-1:0]   in_rad,
	input  eos_pkg::eos_side_t          in_side,
	output logic                        out_valid,
	output eos_pkg::sqrt_acc_t          out_acc,
	output logic [eos_pkg::RAD_W-1:0]   out_rad,
	output eos_pkg::eos_side_t          out_side
);

	eos_pkg::sqrt_acc_t acc_next;

	always_comb begin
		eos_pkg::sqrt_acc_t a;
		a = in_acc;
		for (int i = 0; i < int'(eos_pkg::SQRT_BITS); i++) begin
			a = eos_pkg::sqrt_step(a, in_rad[eos_pkg::RAD_W-1-2*i -: 2]);
		end
		acc_next = a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_acc  <= acc_next;
		out_rad  <= in_rad << (2 * eos_pkg::SQRT_BITS);
		out_side <= in_side;
	end

endmodule

// File: sv/perfect_gas_eos_evaluate_top.sv
// Perfect gas equation of state pipeline, top level.
// Depends on eos_pkg, eos_front, eos_sqrt_stage and assert_macros.svh.
//
// Use:
//   An item (density, spec_energy) is taken at a rising edge with start
//   high and busy low. busy stays low: the pipeline takes one item per clock.
//   Each result shows on the result ports for one cycle with done high.
//   An item passes the front stages, the square root stages and the output
//   register before done rises. Throughput one item per clock.
//   Four multiply stages (32x24 and 26x24 partial products) feed eleven square root
//   stages of four root bits each, then an output register.
//   adiabatic_index is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
//   is always high. Write it only with no item in flight; items read it at
//   their first stage.
//   Reset clears every valid bit and loads gamma with about 1.4; nothing in
//   flight survives. The receiver has no stall: a result not taken in its
//   cycle is gone.
//   Zero density forces wave_speed to 0 and sets zero_density. Pressure
//   above the Q32.32 range reads all ones with pressure_saturated set.
`include "assert_macros.svh"

module perfect_gas_eos_evaluate_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [eos_pkg::IN_W-1:0]           density,
	input  logic [eos_pkg::IN_W-1:0]           spec_energy,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [eos_pkg::GAMMA_W-1:0]        cfg_data,
	output logic                               done,
	output logic [eos_pkg::PRES_W-1:0]         pressure,
	output logic [eos_pkg::ROOT_W-1:0]         wave_speed,
	output logic [eos_pkg::SLOPE_W-1:0]        pressure_energy_slope,
	output logic                               zero_density,
	output logic                               pressure_saturated
);

	logic [eos_pkg::GAMMA_W-1:0] gamma_q;

	logic                         v_sq   [0:eos_pkg::SQRT_STAGES];
	eos_pkg::sqrt_acc_t           acc_sq [0:eos_pkg::SQRT_STAGES];
	logic [eos_pkg::RAD_W-1:0]    rad_sq [0:eos_pkg::SQRT_STAGES];
	eos_pkg::eos_side_t           side_sq[0:eos_pkg::SQRT_STAGES];

	eos_pkg::eos_side_t           side_out;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= eos_pkg::GAMMA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gamma_q <= cfg_data;
		end
	end

	eos_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.gamma       (gamma_q),
		.density     (density),
		.spec_energy (spec_energy),
		.out_valid   (v_sq[0]),
		.radicand    (rad_sq[0]),
		.side        (side_sq[0])
	);

	assign acc_sq[0] = '0;

	for (genvar k = 0; k < eos_pkg::SQRT_STAGES; k++) begin : g_sqrt
		eos_sqrt_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_sq[k]),
			.in_acc    (acc_sq[k]),
			.in_rad    (rad_sq[k]),
			.in_side   (side_sq[k]),
			.out_valid (v_sq[k+1]),
			.out_acc   (acc_sq[k+1]),
			.out_rad   (rad_sq[k+1]),
			.out_side  (side_sq[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sq[eos_pkg::SQRT_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		side_out   <= side_sq[eos_pkg::SQRT_STAGES];
		wave_speed <= side_sq[eos_pkg::SQRT_STAGES].zero_density ? '0
			: acc_sq[eos_pkg::SQRT_STAGES].root;
	end

	assign pressure              = side_out.pressure;
	assign pressure_energy_slope = side_out.slope;
	assign zero_density          = side_out.zero_density;
	assign pressure_saturated    = side_out.pressure_saturated;

	`EOS_ASSERT(a_zero_rho_result, done && zero_density |-> wave_speed == '0 && pressure == '0 && pressure_energy_slope == '0 && !pressure_saturated, "zero density result not cleared")
	`EOS_ASSERT(a_sat_all_ones, done && pressure_saturated |-> pressure == '1, "saturated pressure not all ones")
	`EOS_ASSERT(a_latency, start && !busy |-> ##16 done, "result strobe missing after latency")
	`EOS_ASSERT_ALWAYS(a_never_busy, !busy && cfg_ready, "pipeline refused an item or write")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for perfect_gas_eos_evaluate_top.
// Needs eos_pkg and the RTL. It predicts pressure, slope, sound speed and both flags
// for each accepted item and checks the results in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [eos_pkg::PRES_W-1:0]  pressure;
		logic [eos_pkg::ROOT_W-1:0]  wave_speed;
		logic [eos_pkg::SLOPE_W-1:0] slope;
		logic                        zero_density;
		logic                        saturated;
	} eos_result_t;

	localparam logic [eos_pkg::IN_W-1:0] IN_MAX = '1;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 40;

	class eos_scoreboard;
		eos_result_t pending[$];
		int unsigned errors = 0;

		function automatic eos_result_t gas_state(logic [eos_pkg::IN_W-1:0] rho,
				logic [eos_pkg::IN_W-1:0] e, logic [eos_pkg::GAMMA_W-1:0] g);
			eos_result_t r;
			logic [eos_pkg::GAMMA_W-1:0] gm1;
			logic [127:0] t;
			logic [127:0] y;
			logic [63:0] gg;
			logic [eos_pkg::ROOT_W-1:0] root;
			logic [eos_pkg::ROOT_W-1:0] cand;
			gm1 = (g > eos_pkg::GAMMA_ONE) ? g - eos_pkg::GAMMA_ONE : '0;
			t = 128'(gm1) * 128'(rho);
			r.slope = t[79:28];
			t = 128'(r.slope) * 128'(e);
			r.saturated = (t[127:96] != 0);
			r.pressure = r.saturated ? '1 : t[95:32];
			gg = 64'(g) * 64'(gm1);
			t = 128'(gg) * 128'(e);
			y = t >> 24;
			root = '0;
			for (int b = eos_pkg::ROOT_W - 1; b >= 0; b--) begin
				cand = root | (44'd1 << b);
				if (128'(cand) * 128'(cand) <= y)
					root = cand;
			end
			r.wave_speed = (rho == 0) ? '0 : root;
			r.zero_density = (rho == 0);
			return r;
		endfunction

		function void note_item(logic [eos_pkg::IN_W-1:0] rho, logic [eos_pkg::IN_W-1:0] e,
				logic [eos_pkg::GAMMA_W-1:0] g);
			pending.push_back(gas_state(rho, e, g));
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(eos_result_t got);
			eos_result_t want;
			if (pending.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.pressure !== want.pressure)
				report($sformatf("pressure %h want %h", got.pressure, want.pressure));
			if (got.wave_speed !== want.wave_speed)
				report($sformatf("wave_speed %h want %h", got.wave_speed, want.wave_speed));
			if (got.slope !== want.slope)
				report($sformatf("slope %h want %h", got.slope, want.slope));
			if (got.zero_density !== want.zero_density)
				report($sformatf("zero_density %b want %b", got.zero_density, want.zero_density));
			if (got.saturated !== want.saturated)
				report($sformatf("pressure_saturated %b want %b", got.saturated, want.saturated));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [eos_pkg::IN_W-1:0] density = '0;
	logic [eos_pkg::IN_W-1:0] spec_energy = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [eos_pkg::GAMMA_W-1:0] cfg_data = '0;
	logic done;
	logic [eos_pkg::PRES_W-1:0] pressure;
	logic [eos_pkg::ROOT_W-1:0] wave_speed;
	logic [eos_pkg::SLOPE_W-1:0] pressure_energy_slope;
	logic zero_density;
	logic pressure_saturated;

	eos_scoreboard sb = new();
	logic [eos_pkg::GAMMA_W-1:0] gamma_now = eos_pkg::GAMMA_RESET;
	int unsigned idle_cycles = 0;
	int unsigned max_gap = 19;

	perfect_gas_eos_evaluate_top DUT (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				gamma_now <= cfg_data;
			if (start && !busy)
				sb.note_item(density, spec_energy, gamma_now);
			if (done)
				sb.check_result({pressure, wave_speed, pressure_energy_slope, zero_density,
					pressure_saturated});
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** perfect_gas_eos_evaluate_top: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_item(logic [eos_pkg::IN_W-1:0] rho, logic [eos_pkg::IN_W-1:0] e);
		int unsigned gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		density <= rho;
		spec_energy <= e;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_gamma(logic [eos_pkg::GAMMA_W-1:0] g);
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [eos_pkg::IN_W-1:0] pick_field();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return IN_MAX;
			2: return eos_pkg::IN_W'($urandom_range(1, 255));
			3: return eos_pkg::IN_W'(1) << $urandom_range(0, eos_pkg::IN_W - 1);
			4: return {16'd0, 32'($urandom)};
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	task automatic run_directed();
		send_item('0, '0);
		send_item('0, IN_MAX);
		send_item(IN_MAX, IN_MAX);
		send_item(IN_MAX, '0);
		send_item(48'd1, 48'd1);
		send_item(48'h1_0000_0000, 48'h1_0000_0000);
		send_item(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
		send_item(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
		send_item(48'h0001_0000_0000, IN_MAX);
		send_item(IN_MAX, 48'd1);
	endtask

	initial begin
		logic [eos_pkg::GAMMA_W-1:0] phase_gamma[8];
		int unsigned n;
		phase_gamma = '{eos_pkg::GAMMA_RESET, 32'hFFFF_FFFF, eos_pkg::GAMMA_ONE,
			eos_pkg::GAMMA_ONE + 32'd1,
			eos_pkg::GAMMA_W'($urandom_range(32'h1000_0001, 32'hFFFF_FFFF)), 32'h2000_0000,
			eos_pkg::GAMMA_W'($urandom_range(32'h1000_0001, 32'h3000_0000)),
			eos_pkg::GAMMA_RESET};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int p = 0; p < 8; p++) begin
			if (p != 0)
				write_gamma(phase_gamma[p]);
			if (p < 2)
				run_directed();
			n = 0;
			while (n < 106) begin
				// mix back-to-back bursts with randomly gapped stretches, picked at random per burst
				max_gap = ($urandom_range(0, 2) == 0) ? 0 : 19;
				repeat ($urandom_range(5, 30)) begin
					send_item(pick_field(), pick_field());
					n++;
				end
			end
		end
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** perfect_gas_eos_evaluate_top: PASSED **");
		else
			$display("** perfect_gas_eos_evaluate_top: FAILED **");
		$finish;
	end
endmodule

// File: sim.f
+incdir+sv
sv/eos_pkg.sv
sv/eos_front.sv
sv/eos_sqrt_stage.sv
sv/perfect_gas_eos_evaluate_top.sv
verif/testbench.sv
